[design/ppmd_pkg.sv]
// Shared types, constants and width helpers for the position PID motor drive.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppmd_pkg;

  localparam int POSITION_BITS_DEF  = 32;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int ACTION_W   = 2;
  localparam int DELTA_W    = 16;
  localparam int TGT_W      = 20;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 18;
  localparam int INT_W      = 19;
  localparam int OFS_W      = 15;
  localparam int DRIVE_W    = 15;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam int ERR_DEAD       = 3;
  localparam int ERR_INTEG_MAX  = 100;
  localparam int ERR_BAND_W     = 8;
  localparam int PID_SUM_LIMIT  = 1000;
  localparam int DRIVE_MAX      = 10000;
  localparam int TERM_LIMIT_LOG2 = 61;
  localparam logic [63:0] TERM_LIMIT = 64'd1 << TERM_LIMIT_LOG2;

  localparam logic [GAIN_W-1:0] GAIN_P_RST     = 16'd307;
  localparam logic [GAIN_W-1:0] GAIN_I_RST     = 16'd13;
  localparam logic [GAIN_W-1:0] GAIN_D_RST     = 16'd282;
  localparam logic [ILIM_W-1:0] INT_LIMIT_RST  = 18'd16000;
  localparam logic [TGT_W-1:0]  TARGET_MIN_RST = 20'd100;
  localparam logic [TGT_W-1:0]  TARGET_MAX_RST = 20'd10000;
  localparam logic [OFS_W-1:0]  PWM_OFFSET_RST = 15'd6000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENCODER = 2'd0,
    ACT_TARGET  = 2'd1,
    ACT_PID     = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_INT_LIMIT  = 3'd3,
    CFG_TARGET_MIN = 3'd4,
    CFG_TARGET_MAX = 3'd5,
    CFG_PWM_OFFSET = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic pid;
    logic dead;
  } ppmd_ctl_t;

  // signed error width for a given position width
  function automatic int err_w(input int pos_bits);
    return ((pos_bits > TGT_W + 1) ? pos_bits : TGT_W + 1) + 1;
  endfunction

  // magnitude width of a saturated gain product
  function automatic int prod_mag_w(input int value_w);
    return (value_w + GAIN_W > TERM_LIMIT_LOG2 + 1) ? TERM_LIMIT_LOG2 + 1 : value_w + GAIN_W;
  endfunction

endpackage

`default_nettype wire

[design/position_pid_motor_drive.sv]
// Position PID motor drive: input register, loop-state update with registered
// gain products, then drive calculation into the output register.
// Throughput: one item per cycle while out_tready does not stall the output.
// Reset: synchronous rst_n clears loop state, drive and valid flags and
// restores the configuration registers to their defaults.
`default_nettype none

module position_pid_motor_drive #(
  parameter int POSITION_BITS  = ppmd_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = ppmd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppmd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // encoder_delta [15:0], target_request [35:16], zero [39:36]
  input  logic [ppmd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action [1:0]
  input  logic [ppmd_pkg::ACTION_W-1:0]        in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // drive [14:0], position_now [46:15], target_now [66:47], zero [71:67]
  output logic [ppmd_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import ppmd_pkg::*;

  localparam int ERR_W   = err_w(POSITION_BITS);
  localparam int REQ_LSB = DELTA_W;
  localparam int OUT_PAD = OUT_TDATA_W - DRIVE_W - POS_OUT_W - TGT_W;

  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [ILIM_W-1:0] int_limit_r;
  logic [TGT_W-1:0]  target_min_r, target_max_r;
  logic [OFS_W-1:0]  pwm_offset_r;

  logic                     s1_valid_r;
  action_t                  s1_action_r;
  logic signed [DELTA_W-1:0] s1_delta_r;
  logic [TGT_W-1:0]         s1_req_r;

  logic                            s2_valid_r;
  ppmd_ctl_t                       s2_ctl_r;
  logic signed [POSITION_BITS-1:0] s2_pos_r;
  logic [TGT_W-1:0]                s2_tgt_r;

  logic                 out_valid_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic [TGT_W-1:0]     out_tgt_r;
  logic signed [DRIVE_W-1:0] drive;

  logic adv1, adv2, adv3;

  logic signed [ERR_W-1:0]         err;
  logic signed [ERR_W:0]           diff;
  logic signed [INT_W-1:0]         int_pid;
  ppmd_ctl_t                       ctl;
  logic signed [POSITION_BITS-1:0] pos_after;
  logic [TGT_W-1:0]                tgt_after;

  logic signed [prod_mag_w(ERR_W):0]   prod_p;
  logic signed [prod_mag_w(INT_W):0]   prod_i;
  logic signed [prod_mag_w(ERR_W+1):0] prod_d;

  assign cfg_ready  = 1'b1;
  assign adv3       = !out_valid_r || out_tready;
  assign adv2       = !s2_valid_r || adv3;
  assign adv1       = !s1_valid_r || adv2;
  assign in_tready  = adv1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_tgt_r, out_pos_r, drive};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= GAIN_P_RST;
      gain_i_r     <= GAIN_I_RST;
      gain_d_r     <= GAIN_D_RST;
      int_limit_r  <= INT_LIMIT_RST;
      target_min_r <= TARGET_MIN_RST;
      target_max_r <= TARGET_MAX_RST;
      pwm_offset_r <= PWM_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAIN_P:     gain_p_r     <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:     gain_i_r     <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:     gain_d_r     <= cfg_data[GAIN_W-1:0];
        CFG_INT_LIMIT:  int_limit_r  <= cfg_data[ILIM_W-1:0];
        CFG_TARGET_MIN: target_min_r <= cfg_data[TGT_W-1:0];
        CFG_TARGET_MAX: target_max_r <= cfg_data[TGT_W-1:0];
        CFG_PWM_OFFSET: pwm_offset_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      s1_action_r <= action_t'(in_tuser);
      s1_delta_r  <= signed'(in_tdata[DELTA_W-1:0]);
      s1_req_r    <= in_tdata[REQ_LSB+TGT_W-1:REQ_LSB];
    end
    if (adv2 && s1_valid_r) begin
      s2_ctl_r <= ctl;
      s2_pos_r <= pos_after;
      s2_tgt_r <= tgt_after;
    end
    if (adv3 && s2_valid_r) begin
      out_pos_r <= POS_OUT_W'(s2_pos_r);
      out_tgt_r <= s2_tgt_r;
    end
  end

  ppmd_loop_state #(
    .POSITION_BITS (POSITION_BITS)
  ) u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (s1_valid_r && adv2),
    .action         (s1_action_r),
    .delta          (s1_delta_r),
    .req            (s1_req_r),
    .target_min     (target_min_r),
    .target_max     (target_max_r),
    .integral_limit (int_limit_r),
    .err            (err),
    .diff           (diff),
    .int_pid        (int_pid),
    .ctl            (ctl),
    .pos_after      (pos_after),
    .tgt_after      (tgt_after)
  );

  ppmd_gain_mul #(.VALUE_W(ERR_W)) u_mul_p (
    .clk       (clk),
    .en        (adv2),
    .value     (err),
    .gain      (gain_p_r),
    .product_r (prod_p)
  );

  ppmd_gain_mul #(.VALUE_W(INT_W)) u_mul_i (
    .clk       (clk),
    .en        (adv2),
    .value     (int_pid),
    .gain      (gain_i_r),
    .product_r (prod_i)
  );

  ppmd_gain_mul #(.VALUE_W(ERR_W + 1)) u_mul_d (
    .clk       (clk),
    .en        (adv2),
    .value     (diff),
    .gain      (gain_d_r),
    .product_r (prod_d)
  );

  ppmd_drive_calc #(
    .ERR_W          (ERR_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_drive (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv3),
    .s2_valid   (s2_valid_r),
    .ctl        (s2_ctl_r),
    .prod_p     (prod_p),
    .prod_i     (prod_i),
    .prod_d     (prod_d),
    .pwm_offset (pwm_offset_r),
    .drive_r    (drive)
  );

endmodule

`default_nettype wire

[design/ppmd_gain_mul.sv]
// One registered gain lane: signed value times unsigned gain, magnitude
// saturated at the term limit. Depends on ppmd_pkg.
`default_nettype none

module ppmd_gain_mul #(
  parameter int VALUE_W = 33
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic signed [VALUE_W-1:0]                  value,
  input  logic        [ppmd_pkg::GAIN_W-1:0]         gain,
  output logic signed [ppmd_pkg::prod_mag_w(VALUE_W):0] product_r
);
  import ppmd_pkg::*;

  localparam int PW = VALUE_W + GAIN_W;
  localparam int MW = prod_mag_w(VALUE_W);

  logic [VALUE_W-1:0]  mag;
  logic [PW-1:0]       raw;
  logic                sat_hit;
  logic [MW-1:0]       sat;
  logic signed [MW:0]  product_nxt;

  always_comb begin
    mag         = value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
    raw         = PW'(mag) * PW'(gain);
    sat_hit     = (PW > MW) && (raw > PW'(TERM_LIMIT));
    sat         = sat_hit ? MW'(TERM_LIMIT) : MW'(raw);
    product_nxt = value[VALUE_W-1] ? -signed'({1'b0, sat}) : signed'({1'b0, sat});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= product_nxt;
    end
  end

endmodule

`default_nettype wire

[design/ppmd_loop_state.sv]
// Loop state: position, target, error integral and previous error, updated
// once per item; feeds error terms to the gain lanes. Depends on ppmd_pkg.
`default_nettype none

module ppmd_loop_state #(
  parameter int POSITION_BITS = ppmd_pkg::POSITION_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               upd,
  input  ppmd_pkg::action_t                                  action,
  input  logic signed [ppmd_pkg::DELTA_W-1:0]                delta,
  input  logic        [ppmd_pkg::TGT_W-1:0]                  req,
  input  logic        [ppmd_pkg::TGT_W-1:0]                  target_min,
  input  logic        [ppmd_pkg::TGT_W-1:0]                  target_max,
  input  logic        [ppmd_pkg::ILIM_W-1:0]                 integral_limit,
  output logic signed [ppmd_pkg::err_w(POSITION_BITS)-1:0]   err,
  output logic signed [ppmd_pkg::err_w(POSITION_BITS):0]     diff,
  output logic signed [ppmd_pkg::INT_W-1:0]                  int_pid,
  output ppmd_pkg::ppmd_ctl_t                                ctl,
  output logic signed [POSITION_BITS-1:0]                    pos_after,
  output logic        [ppmd_pkg::TGT_W-1:0]                  tgt_after
);
  import ppmd_pkg::*;

  localparam int EW = err_w(POSITION_BITS);
  localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
  localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};

  logic signed [POSITION_BITS-1:0] position_r, position_nxt;
  logic        [TGT_W-1:0]         target_r, target_nxt;
  logic signed [INT_W-1:0]         integral_r, integral_nxt;
  logic signed [EW-1:0]            prev_err_r, prev_err_nxt;

  logic signed [POSITION_BITS:0]   pos_sum;
  logic signed [POSITION_BITS-1:0] pos_sat;
  logic        [TGT_W-1:0]         tgt_set;
  logic        [EW-1:0]            emag;
  logic                            in_band;
  logic signed [INT_W:0]           lim;
  logic signed [INT_W:0]           int_sum;
  logic signed [INT_W:0]           int_clamped;

  always_comb begin
    pos_sum = (POSITION_BITS+1)'(position_r) + (POSITION_BITS+1)'(delta);
    if (pos_sum[POSITION_BITS] != pos_sum[POSITION_BITS-1]) begin
      pos_sat = pos_sum[POSITION_BITS] ? POS_MIN : POS_MAX;
    end else begin
      pos_sat = POSITION_BITS'(pos_sum);
    end

    if (req > target_max) begin
      tgt_set = target_max;
    end else if (req < target_min) begin
      tgt_set = target_min;
    end else begin
      tgt_set = req;
    end

    err     = EW'(signed'({1'b0, target_r})) - EW'(position_r);
    emag    = err[EW-1] ? EW'(-err) : EW'(err);
    in_band = (emag >= EW'(ERR_DEAD)) && (emag <= EW'(ERR_INTEG_MAX));
    diff    = (EW+1)'(err) - (EW+1)'(prev_err_r);

    lim     = signed'((INT_W+1)'(integral_limit));
    int_sum = (INT_W+1)'(integral_r) + (INT_W+1)'(signed'(err[ERR_BAND_W-1:0]));
    if (int_sum > lim) begin
      int_clamped = lim;
    end else if (int_sum < -lim) begin
      int_clamped = -lim;
    end else begin
      int_clamped = int_sum;
    end
    int_pid = in_band ? INT_W'(int_clamped) : '0;

    ctl.pid  = (action == ACT_PID);
    ctl.dead = (emag <= EW'(ERR_DEAD));

    position_nxt = position_r;
    target_nxt   = target_r;
    integral_nxt = integral_r;
    prev_err_nxt = prev_err_r;
    case (action)
      ACT_ENCODER: position_nxt = pos_sat;
      ACT_TARGET:  target_nxt   = tgt_set;
      ACT_PID: begin
        integral_nxt = int_pid;
        prev_err_nxt = err;
      end
      default: ;
    endcase

    pos_after = position_nxt;
    tgt_after = target_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      target_r   <= '0;
      integral_r <= '0;
      prev_err_r <= '0;
    end else if (upd) begin
      position_r <= position_nxt;
      target_r   <= target_nxt;
      integral_r <= integral_nxt;
      prev_err_r <= prev_err_nxt;
    end
  end

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd && action == ACT_ENCODER) |=> $stable(position_r))
    else $error("position changed without an encoder item");

  a_tgt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd && action == ACT_TARGET) |=> $stable(target_r))
    else $error("target changed without a set-target item");

  a_int_clear: assert property (@(posedge clk) disable iff (!rst_n)
    upd && action == ACT_PID && emag > EW'(ERR_INTEG_MAX) |=> integral_r == '0)
    else $error("integral not cleared outside the integration band");

endmodule

`default_nettype wire

[design/ppmd_drive_calc.sv]
// Drive stage: sums the gain products, clamps, scales and applies the
// dead-zone offset into the held drive register. Depends on ppmd_pkg.
`default_nettype none

module ppmd_drive_calc #(
  parameter int ERR_W          = 33,
  parameter int GAIN_FRAC_BITS = ppmd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                adv,
  input  logic                                                s2_valid,
  input  ppmd_pkg::ppmd_ctl_t                                 ctl,
  input  logic signed [ppmd_pkg::prod_mag_w(ERR_W):0]         prod_p,
  input  logic signed [ppmd_pkg::prod_mag_w(ppmd_pkg::INT_W):0] prod_i,
  input  logic signed [ppmd_pkg::prod_mag_w(ERR_W+1):0]       prod_d,
  input  logic        [ppmd_pkg::OFS_W-1:0]                   pwm_offset,
  output logic signed [ppmd_pkg::DRIVE_W-1:0]                 drive_r
);
  import ppmd_pkg::*;

  localparam int SW      = prod_mag_w(ERR_W + 1) + 3;
  localparam int SUM_LIM = PID_SUM_LIMIT << GAIN_FRAC_BITS;
  localparam int CW      = $clog2(SUM_LIM + 1);
  localparam int QW      = CW + 2;

  logic signed [SW-1:0]      sum;
  logic        [SW-1:0]      smag;
  logic        [CW-1:0]      cmag;
  logic        [QW-1:0]      qm;
  logic                      small_q;
  logic        [OFS_W:0]     dm_sum;
  logic        [DRIVE_W-1:0] dm;
  logic signed [DRIVE_W-1:0] drive_pid;
  logic signed [DRIVE_W-1:0] drive_nxt;

  always_comb begin
    sum  = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);
    smag = sum[SW-1] ? SW'(-sum) : SW'(sum);
    if (ctl.dead) begin
      cmag = '0;
    end else if (smag > SW'(SUM_LIM)) begin
      cmag = CW'(SUM_LIM);
    end else begin
      cmag = CW'(smag);
    end
    qm      = {cmag, 2'b00};
    small_q = (qm <= QW'(1 << (GAIN_FRAC_BITS - 1)));
    dm_sum  = (OFS_W+1)'(qm >> GAIN_FRAC_BITS) + (OFS_W+1)'(pwm_offset);
    dm      = (dm_sum > (OFS_W+1)'(DRIVE_MAX)) ? DRIVE_W'(DRIVE_MAX) : DRIVE_W'(dm_sum);
    if (small_q) begin
      drive_pid = '0;
    end else begin
      drive_pid = sum[SW-1] ? -signed'(dm) : signed'(dm);
    end
    drive_nxt = ctl.pid ? drive_pid : drive_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
    end else if (adv && s2_valid) begin
      drive_r <= drive_nxt;
    end
  end

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_r <= signed'(DRIVE_W'(DRIVE_MAX))) && (drive_r >= -signed'(DRIVE_W'(DRIVE_MAX))))
    else $error("drive outside its range");

  a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s2_valid && ctl.pid) |=> $stable(drive_r))
    else $error("drive changed without a PID item");

  a_drive_dead: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_valid && ctl.pid && ctl.dead |=> drive_r == '0)
    else $error("nonzero drive inside the error dead band");

endmodule

`default_nettype wire
